FILE: rtl/qbd_pkg.sv
// Package for the quaternion boxcar decimator: types and constants.
package qbd_pkg;

   localparam int NumScalar = 4;
   localparam int MaxRatio = 256;
   localparam int QuatFracBits = 14;
   localparam int RatioWidth = 9;
   localparam int QuatSumWidth = 24;
   localparam int ScalarSumWidth = 32;

   localparam logic [RatioWidth-1:0] RatioMax = RatioWidth'(MaxRatio);

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [23:0] scalar_a;
      logic signed [23:0] scalar_b;
      logic signed [23:0] scalar_c;
      logic signed [23:0] scalar_d;
      logic [31:0]        stamp;
      logic [15:0]        status;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] avg_quat_w;
      logic signed [15:0] avg_quat_x;
      logic signed [15:0] avg_quat_y;
      logic signed [15:0] avg_quat_z;
      logic signed [23:0] avg_scalar_a;
      logic signed [23:0] avg_scalar_b;
      logic signed [23:0] avg_scalar_c;
      logic signed [23:0] avg_scalar_d;
      logic [31:0]        last_stamp;
      logic [15:0]        last_status;
   } rsp_payload_type;

   // Divider unit command and status
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_sts_type;

endpackage

FILE: rtl/quaternion_boxcar_decimator.sv
// Quaternion boxcar decimator: top level with sequencer and shared datapath.
// Each sample takes a dot product with the running sum, then a sum update; the first of a
// window only loads the sums. A closing sample then adds 4 squares, 25 root steps, 8 divides
// (the four quaternion divides are skipped for an all-zero quaternion sum) and 1 output step.
// One transaction at a time; req_stall is high while the sequencer is busy, and a finished
// result waits in its own register. Sync active-high reset clears state, ratio, count, sums, stamp, status, valid.
module quaternion_boxcar_decimator import qbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write,
   input  logic [8:0]      csr_wdata
);

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StDot  = 4'd1;
   localparam logic [3:0] StAdd  = 4'd2;
   localparam logic [3:0] StSq   = 4'd3;
   localparam logic [3:0] StRoot = 4'd4;
   localparam logic [3:0] StQDiv = 4'd5;
   localparam logic [3:0] StSDiv = 4'd6;
   localparam logic [3:0] StWait = 4'd7;
   localparam logic [3:0] StOut  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [RatioWidth-1:0] ratio_ff, ratio_in;
   logic [RatioWidth-1:0] count_ff, count_in;
   logic signed [QuatSumWidth-1:0]   qsum_ff [4];
   logic signed [QuatSumWidth-1:0]   qsum_in [4];
   logic signed [ScalarSumWidth-1:0] ssum_ff [NumScalar];
   logic signed [ScalarSumWidth-1:0] ssum_in [NumScalar];
   logic [31:0] stamp_ff, stamp_in;
   logic [15:0] status_ff, status_in;
   req_payload_type item_ff, item_in;
   logic [1:0]  idx_ff, idx_in;
   logic signed [49:0] acc_ff, acc_in;
   logic [5:0]  step_ff, step_in;
   logic [49:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic        neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   rsp_payload_type res_ff, res_in;

   logic signed [15:0] qin [4];
   logic signed [23:0] sin [NumScalar];
   logic signed [QuatSumWidth-1:0] mul_a;
   logic signed [QuatSumWidth-1:0] mul_b;
   logic signed [47:0] prod;
   logic signed [QuatSumWidth:0] qadd;
   logic signed [ScalarSumWidth:0] sadd;
   logic [49:0] rtrial;
   logic [49:0] rpart;
   logic [63:0] mag;
   logic        sign_in;
   logic [63:0] qmag;
   div_cmd_type dcmd;
   div_sts_type dsts;
   logic [63:0] squot;
   logic        accept;

   qbd_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   assign qin[0] = item_ff.quat_w;
   assign qin[1] = item_ff.quat_x;
   assign qin[2] = item_ff.quat_y;
   assign qin[3] = item_ff.quat_z;
   assign sin[0] = item_ff.scalar_a;
   assign sin[1] = item_ff.scalar_b;
   assign sin[2] = item_ff.scalar_c;
   assign sin[3] = item_ff.scalar_d;

   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && !req_stall;

   // Shared multiplier
   assign mul_a = qsum_ff[idx_ff];
   assign mul_b = (state_ff == StDot) ? QuatSumWidth'(qin[idx_ff]) : qsum_ff[idx_ff];
   assign prod  = mul_a * mul_b;

   assign qadd  = {qsum_ff[idx_ff][QuatSumWidth-1], qsum_ff[idx_ff]}
                + (acc_ff < 0 ? -(QuatSumWidth+1)'(qin[idx_ff])
                              : (QuatSumWidth+1)'(qin[idx_ff]));
   assign sadd  = {ssum_ff[idx_ff][ScalarSumWidth-1], ssum_ff[idx_ff]}
                + (ScalarSumWidth+1)'(sin[idx_ff]);

   // Square root: two bits of the sum of squares per step
   assign rtrial = 50'({root_ff, 2'b01});
   assign rpart  = {acc_ff[47:0], rem_ff[49:48]};

   assign sign_in = (state_ff == StQDiv) ? qsum_ff[idx_ff][QuatSumWidth-1]
                                          : ssum_ff[idx_ff][ScalarSumWidth-1];
   assign qmag  = 64'(qsum_ff[idx_ff][QuatSumWidth-1] ?
                      -(QuatSumWidth+1)'(qsum_ff[idx_ff]) : (QuatSumWidth+1)'(qsum_ff[idx_ff]));
   assign mag   = (state_ff == StQDiv) ? (qmag << QuatFracBits)
                 : 64'(ssum_ff[idx_ff][ScalarSumWidth-1] ?
                       -33'(ssum_ff[idx_ff]) : 33'(ssum_ff[idx_ff]));
   assign squot = neg_ff ? -dsts.quotient : dsts.quotient;

   always_comb begin
      state_in     = state_ff;
      ratio_in     = ratio_ff;
      count_in     = count_ff;
      qsum_in      = qsum_ff;
      ssum_in      = ssum_ff;
      stamp_in     = stamp_ff;
      status_in    = status_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      dcmd.start    = 1'b0;
      dcmd.dividend = mag;
      dcmd.divisor  = 64'(root_ff);
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         StIdle: begin
            if (accept && ratio_ff != '0) begin
               item_in  = req_payload;
               idx_in   = '0;
               acc_in   = '0;
               state_in = StDot;
            end
         end
         StDot: begin
            if (count_ff == '0) begin
               for (int i = 0; i < 4; i++) qsum_in[i] = QuatSumWidth'(qin[i]);
               for (int i = 0; i < NumScalar; i++)
                  ssum_in[i] = ScalarSumWidth'(sin[i]);
               count_in = RatioWidth'(1);
               stamp_in = item_ff.stamp;
               status_in = item_ff.status;
               idx_in   = '0;
               state_in = StSq;
               acc_in   = '0;
               if (RatioWidth'(1) < ratio_ff) state_in = StIdle;
            end else begin
               acc_in = acc_ff + 50'(prod);
               if (idx_ff == 2'd3) begin
                  idx_in   = '0;
                  state_in = StAdd;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         StAdd: begin
            if (qadd > (QuatSumWidth+1)'(2**(QuatSumWidth-1) - 1))
               qsum_in[idx_ff] = QuatSumWidth'(2**(QuatSumWidth-1) - 1);
            else if (qadd < -(QuatSumWidth+1)'(2**(QuatSumWidth-1)))
               qsum_in[idx_ff] = QuatSumWidth'(-(2**(QuatSumWidth-1)));
            else
               qsum_in[idx_ff] = qadd[QuatSumWidth-1:0];
            if (sadd > (ScalarSumWidth+1)'(33'sh0_7FFF_FFFF))
               ssum_in[idx_ff] = 32'sh7FFF_FFFF;
            else if (sadd < 33'sh1_8000_0000)
               ssum_in[idx_ff] = 32'sh8000_0000;
            else
               ssum_in[idx_ff] = sadd[ScalarSumWidth-1:0];
            if (idx_ff == 2'd3) begin
               count_in  = count_ff + RatioWidth'(1);
               stamp_in  = item_ff.stamp;
               status_in = item_ff.status;
               idx_in    = '0;
               acc_in    = '0;
               state_in  = (count_ff + RatioWidth'(1) < ratio_ff) ? StIdle : StSq;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         StSq: begin
            acc_in = acc_ff + 50'(prod);
            if (idx_ff == 2'd3) begin
               rem_in   = acc_ff + 50'(prod);
               acc_in   = '0;
               root_in  = '0;
               step_in  = 6'd25;
               state_in = StRoot;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         StRoot: begin
            rem_in = {rem_ff[47:0], 2'b00};
            if (rpart >= rtrial) begin
               acc_in  = rpart - rtrial;
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               acc_in  = rpart;
               root_in = {root_ff[23:0], 1'b0};
            end
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               idx_in   = '0;
               state_in = StQDiv;
            end
         end
         StQDiv, StSDiv: begin
            if (!dsts.busy) begin
               dcmd.start = 1'b1;
               if (state_ff == StSDiv) dcmd.divisor = 64'(count_ff);
               neg_in   = sign_in;
               state_in = StWait;
               step_in  = {5'd0, state_ff == StSDiv};
               if (state_ff == StQDiv && root_ff == '0) begin
                  dcmd.start = 1'b0;
                  res_in.avg_quat_w = '0;
                  res_in.avg_quat_x = '0;
                  res_in.avg_quat_y = '0;
                  res_in.avg_quat_z = '0;
                  idx_in   = '0;
                  state_in = StSDiv;
               end
            end
         end
         StWait: begin
            if (dsts.done) begin
               if (step_ff[0] == 1'b0) begin
                  case (idx_ff)
                     2'd0: res_in.avg_quat_w = squot[15:0];
                     2'd1: res_in.avg_quat_x = squot[15:0];
                     2'd2: res_in.avg_quat_y = squot[15:0];
                     default: res_in.avg_quat_z = squot[15:0];
                  endcase
               end else begin
                  case (idx_ff)
                     2'd0: res_in.avg_scalar_a = squot[23:0];
                     2'd1: res_in.avg_scalar_b = squot[23:0];
                     2'd2: res_in.avg_scalar_c = squot[23:0];
                     default: res_in.avg_scalar_d = squot[23:0];
                  endcase
               end
               if (idx_ff == 2'd3) begin
                  idx_in   = '0;
                  state_in = step_ff[0] ? StOut : StSDiv;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = step_ff[0] ? StSDiv : StQDiv;
               end
            end
         end
         StOut: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in             = res_ff;
               rsp_in.last_stamp  = stamp_ff;
               rsp_in.last_status = status_ff;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      if (csr_write) begin
         ratio_in = (csr_wdata > RatioMax) ? RatioMax : csr_wdata;
         count_in = '0;
         for (int i = 0; i < 4; i++) qsum_in[i] = '0;
         for (int i = 0; i < NumScalar; i++) ssum_in[i] = '0;
         stamp_in  = '0;
         status_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ratio_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         stamp_ff     <= '0;
         status_ff    <= '0;
         for (int i = 0; i < 4; i++) qsum_ff[i] <= '0;
         for (int i = 0; i < NumScalar; i++) ssum_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         ratio_ff     <= ratio_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         stamp_ff     <= stamp_in;
         status_ff    <= status_in;
         qsum_ff      <= qsum_in;
         ssum_ff      <= ssum_in;
      end
      item_ff <= item_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
      res_ff  <= res_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != StIdle |-> req_stall)
      else $error("input taken while busy");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ratio_ff || ratio_ff == '0)
      else $error("count beyond ratio");

endmodule

FILE: rtl/qbd_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module qbd_divider import qbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = cmd.dividend;
         den_in  = cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule
